// ===== rtl/fragment_reassembly_tracker_top_defines.svh =====
// ----------------------------------------------------------------------------
// Fragment reassembly tracker - assertion macros
// Shared concurrent check forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef FRAGMENT_REASSEMBLY_TRACKER_TOP_DEFINES_SVH
`define FRAGMENT_REASSEMBLY_TRACKER_TOP_DEFINES_SVH

// Same-cycle implication
`define FRT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define FRT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/frt_pkg.sv =====
// ----------------------------------------------------------------------------
// Fragment reassembly tracker - package
// Sizes, codes, payload structs and the command/status bundles.
// ----------------------------------------------------------------------------
package frt_pkg;

  // Table geometry
  localparam int SLOTS          = 8;
  localparam int MAX_FRAGMENTS  = 64;
  localparam int HEADER_BYTES   = 44;
  localparam int SLOT_W         = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int FRAG_IDX_W     = (MAX_FRAGMENTS > 1) ? $clog2(MAX_FRAGMENTS) : 1;

  // Field widths
  localparam int FRAME_W    = 32;
  localparam int IDX_W      = 16;
  localparam int LEN_W      = 16;
  localparam int PAYLOAD_W  = 16;
  localparam int COUNT_W    = 7;
  localparam int LIMIT_W    = 23;
  localparam int OFFSET_W   = 23;
  localparam int PROD_W     = FRAG_IDX_W + PAYLOAD_W;
  localparam int END_W      = PROD_W + 2;

  // APB
  localparam int ADDR_W     = 4;
  localparam int DATA_W     = 32;

  // Register reset values
  localparam logic [PAYLOAD_W-1:0] PAYLOAD_RST = PAYLOAD_W'(1456);
  localparam logic [COUNT_W-1:0]   COUNT_RST   = COUNT_W'(1);
  localparam logic [LIMIT_W-1:0]   LIMIT_RST   = LIMIT_W'(1456);

  // Register indexes
  typedef enum logic [1:0] {
    REG_PAYLOAD_BYTES = 2'd0,
    REG_FRAG_COUNT    = 2'd1,
    REG_PACKET_LIMIT  = 2'd2
  } frt_reg_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_ACCEPTED  = 2'd0,
    ST_TOO_LONG  = 2'd1,
    ST_BAD_INDEX = 2'd2
  } frt_status_t;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOKUP,
    S_EVICT,
    S_UPDATE
  } frt_state_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame_count;
    logic [IDX_W-1:0]   fragment_index;
    logic [LEN_W-1:0]   received_length;
  } frt_in_t;

  typedef struct packed {
    logic [2:0]          slot_index;
    frt_status_t         status;
    logic [OFFSET_W-1:0] write_offset;
    logic                evicted;
    logic                complete;
  } frt_out_t;

  typedef struct packed {
    logic [PAYLOAD_W-1:0] fragment_payload_bytes;
    logic [COUNT_W-1:0]   frag_total;
    logic [LIMIT_W-1:0]   packet_limit_bytes;
  } frt_cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic lookup;
    logic scan;
    logic commit;
  } frt_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_evict;
    logic scan_done;
    logic out_free;
  } frt_stat_t;

endpackage

// ===== rtl/fragment_reassembly_tracker_top.sv =====
// ----------------------------------------------------------------------------
// Fragment reassembly tracker - top level
// Tracks which fragments of each in-flight frame have arrived.
// ----------------------------------------------------------------------------
// Each request carries one fragment header (frame count, fragment index,
// received length) and yields exactly one result: the table slot, a status,
// the payload write offset, an eviction flag and a completion flag. The block
// works on one request at a time. A request passes through capture, parallel
// slot match and table update: its result is loaded by the update, and the
// next request can be taken once the controller is idle again. When all 8
// slots hold other frames, the oldest slot is found by a scan that reads one
// slot key per cycle, ahead of the table update. The next request is
// taken while the previous result waits in the output register; a result
// still held by result_stall delays the update. Write the configuration only
// while no request is in flight.
// ----------------------------------------------------------------------------
`include "fragment_reassembly_tracker_top_defines.svh"

module fragment_reassembly_tracker_top (
  input  logic                       clk,
  input  logic                       rst,
  // fragment headers
  input  logic                       frag_valid,
  output logic                       frag_stall,
  input  frt_pkg::frt_in_t           frag,
  // results
  output logic                       result_valid,
  input  logic                       result_stall,
  output frt_pkg::frt_out_t          result,
  // configuration
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [frt_pkg::ADDR_W-1:0] paddr,
  input  logic [frt_pkg::DATA_W-1:0] pwdata,
  output logic [frt_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import frt_pkg::*;

  frt_cfg_t  cfg;
  frt_cmd_t  cmd;
  frt_stat_t stat;

  frt_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  frt_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .frag_valid (frag_valid),
    .frag_stall (frag_stall),
    .stat       (stat),
    .cmd        (cmd)
  );

  frt_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .frag         (frag),
    .result       (result),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .cmd          (cmd),
    .stat         (stat)
  );

  // Checks
  `FRT_ASSERT_NEXT(a_busy_after_accept, frag_valid && !frag_stall, frag_stall,
    "request accepted while busy")
  `FRT_ASSERT_NEXT(a_commit_loads_result, cmd.commit, result_valid,
    "update did not load result")
  `FRT_ASSERT_SAME(a_commit_needs_room, cmd.commit, !result_valid || !result_stall,
    "result overwritten")
  `FRT_ASSERT_SAME(a_offset_only_accepted, result_valid && result.write_offset != '0,
    result.status == ST_ACCEPTED, "offset on rejected fragment")

endmodule

// ===== rtl/frt_regs.sv =====
// ----------------------------------------------------------------------------
// Fragment reassembly tracker - configuration registers
// APB-style register file: payload bytes, fragment count, packet limit.
// ----------------------------------------------------------------------------
module frt_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [frt_pkg::ADDR_W-1:0] paddr,
  input  logic [frt_pkg::DATA_W-1:0] pwdata,
  output logic [frt_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output frt_pkg::frt_cfg_t          cfg
);
  import frt_pkg::*;

  frt_reg_t reg_sel;
  logic     wr_en;

  assign reg_sel = frt_reg_t'(paddr[3:2]);
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fragment_payload_bytes <= PAYLOAD_RST;
      cfg.frag_total             <= COUNT_RST;
      cfg.packet_limit_bytes     <= LIMIT_RST;
    end else if (wr_en) begin
      case (reg_sel)
        REG_PAYLOAD_BYTES: cfg.fragment_payload_bytes <= pwdata[PAYLOAD_W-1:0];
        REG_FRAG_COUNT:    cfg.frag_total             <= pwdata[COUNT_W-1:0];
        REG_PACKET_LIMIT:  cfg.packet_limit_bytes     <= pwdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (reg_sel)
      REG_PAYLOAD_BYTES: prdata = DATA_W'(cfg.fragment_payload_bytes);
      REG_FRAG_COUNT:    prdata = DATA_W'(cfg.frag_total);
      REG_PACKET_LIMIT:  prdata = DATA_W'(cfg.packet_limit_bytes);
      default:           prdata = '0;
    endcase
  end

endmodule

// ===== rtl/frt_ctrl.sv =====
// ----------------------------------------------------------------------------
// Fragment reassembly tracker - controller
// Sequences one request through lookup, eviction scan and table update.
// ----------------------------------------------------------------------------
module frt_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               frag_valid,
  output logic               frag_stall,
  input  frt_pkg::frt_stat_t stat,
  output frt_pkg::frt_cmd_t  cmd
);
  import frt_pkg::*;

  frt_state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    frag_stall = 1'b1;
    case (state)
      S_IDLE: begin
        frag_stall = 1'b0;
        if (frag_valid) begin
          cmd.load   = 1'b1;
          state_next = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_next = stat.need_evict ? S_EVICT : S_UPDATE;
      end
      S_EVICT: begin
        cmd.scan = 1'b1;
        if (stat.scan_done) begin
          state_next = S_UPDATE;
        end
      end
      S_UPDATE: begin
        // hold until the result register can take the request
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/frt_dp.sv =====
// ----------------------------------------------------------------------------
// Fragment reassembly tracker - datapath
// Slot table, parallel key match, oldest-slot scan, fragment check, result reg.
// ----------------------------------------------------------------------------
module frt_dp (
  input  logic               clk,
  input  logic               rst,
  input  frt_pkg::frt_cfg_t  cfg,
  input  frt_pkg::frt_in_t   frag,
  output frt_pkg::frt_out_t  result,
  output logic               result_valid,
  input  logic               result_stall,
  input  frt_pkg::frt_cmd_t  cmd,
  output frt_pkg::frt_stat_t stat
);
  import frt_pkg::*;

  // Slot table
  logic [SLOTS-1:0]         slot_valid;
  logic [FRAME_W-1:0]       slot_frame  [SLOTS];
  logic [MAX_FRAGMENTS-1:0] slot_bitmap [SLOTS];

  // Request registers
  logic [FRAME_W-1:0] frame_q;
  logic [IDX_W-1:0]   idx_q;
  logic [LEN_W-1:0]   len_q;
  logic               claim;
  logic               evict;
  logic [SLOT_W-1:0]  sel_slot;
  logic [PROD_W-1:0]  prod;
  logic [FRAME_W-1:0] min_frame;
  logic [SLOT_W-1:0]  scan_idx;

  // Lookup logic
  logic [SLOTS-1:0]  hit_vec;
  logic [SLOT_W-1:0] hit_slot;
  logic [SLOT_W-1:0] free_slot;
  logic              any_hit;
  logic              any_free;

  // Update logic
  logic [COUNT_W-1:0]       cnt_eff;
  logic [MAX_FRAGMENTS-1:0] cnt_mask;
  logic [MAX_FRAGMENTS-1:0] cur_bitmap;
  logic [MAX_FRAGMENTS-1:0] set_bit;
  logic [MAX_FRAGMENTS-1:0] new_bitmap;
  logic [END_W-1:0]         end_byte;
  logic                     set_en;
  logic                     complete;
  frt_status_t              status;

  // Parallel key match and first free slot; lowest index wins
  always_comb begin
    hit_slot  = '0;
    free_slot = '0;
    for (int i = 0; i < SLOTS; i++) begin
      hit_vec[i] = slot_valid[i] && (slot_frame[i] == frame_q);
    end
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (hit_vec[i]) hit_slot = SLOT_W'(i);
      if (!slot_valid[i]) free_slot = SLOT_W'(i);
    end
    any_hit  = |hit_vec;
    any_free = ~&slot_valid;
  end

  assign stat.need_evict = !any_hit && !any_free;
  assign stat.scan_done  = (scan_idx == SLOT_W'(SLOTS - 1));
  assign stat.out_free   = !result_valid || !result_stall;

  // Request capture, lookup result and eviction scan
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      frame_q <= frag.frame_count;
      idx_q   <= frag.fragment_index;
      len_q   <= frag.received_length;
    end
    if (cmd.lookup) begin
      claim     <= !any_hit;
      evict     <= !any_hit && !any_free;
      sel_slot  <= any_hit ? hit_slot : (any_free ? free_slot : '0);
      prod      <= PROD_W'(idx_q[FRAG_IDX_W-1:0]) * PROD_W'(cfg.fragment_payload_bytes);
      min_frame <= slot_frame[0];
      scan_idx  <= SLOT_W'(1);
    end
    if (cmd.scan) begin
      // strict less-than keeps the lowest index on a tie
      if (slot_frame[scan_idx] < min_frame) begin
        min_frame <= slot_frame[scan_idx];
        sel_slot  <= scan_idx;
      end
      scan_idx <= scan_idx + SLOT_W'(1);
    end
  end

  // Effective fragment count and its bitmap mask
  always_comb begin
    if (cfg.frag_total == '0) begin
      cnt_eff = COUNT_W'(1);
    end else if (cfg.frag_total > COUNT_W'(MAX_FRAGMENTS)) begin
      cnt_eff = COUNT_W'(MAX_FRAGMENTS);
    end else begin
      cnt_eff = cfg.frag_total;
    end
    cnt_mask = {MAX_FRAGMENTS{1'b1}} >> (COUNT_W'(MAX_FRAGMENTS) - cnt_eff);
  end

  // Fragment judgement and completion
  always_comb begin
    end_byte = END_W'(prod) + END_W'(len_q - LEN_W'(HEADER_BYTES));
    status   = ST_ACCEPTED;
    set_en   = 1'b0;
    if (idx_q == '0) begin
      set_en = 1'b1;
    end else if (idx_q >= IDX_W'(cnt_eff)) begin
      status = ST_BAD_INDEX;
    end else if (len_q < LEN_W'(HEADER_BYTES)) begin
      status = ST_TOO_LONG;
    end else if (end_byte <= END_W'(cfg.packet_limit_bytes)) begin
      set_en = 1'b1;
    end else begin
      status = ST_TOO_LONG;
    end
    cur_bitmap = claim ? '0 : slot_bitmap[sel_slot];
    set_bit    = set_en ? (MAX_FRAGMENTS'(1) << idx_q[FRAG_IDX_W-1:0]) : '0;
    new_bitmap = cur_bitmap | set_bit;
    complete   = (new_bitmap & cnt_mask) == cnt_mask;
  end

  // Table valid bits and bitmaps
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        slot_bitmap[i] <= '0;
      end
    end else if (cmd.commit) begin
      slot_valid[sel_slot]  <= !complete;
      slot_bitmap[sel_slot] <= complete ? '0 : new_bitmap;
    end
  end

  // Frame keys, no reset: read only while valid
  always_ff @(posedge clk) begin
    if (cmd.commit && claim) begin
      slot_frame[sel_slot] <= frame_q;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.commit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      result.slot_index   <= 3'(sel_slot);
      result.status       <= status;
      result.write_offset <= (set_en && idx_q != '0) ? OFFSET_W'(prod) : '0;
      result.evicted      <= evict;
      result.complete     <= complete;
    end
  end

endmodule
